// ----- src/bdf_pkg.sv -----
// Package for the block deframer: status codes, register indexes, header masks
// and the result record type.
// Used by block_deframer_top and the testbench; depends on nothing.
`default_nettype none

package bdf_pkg;

   // configuration register indexes
   localparam logic CSR_WORD_MODE    = 1'b0;
   localparam logic CSR_BUFFER_LIMIT = 1'b1;

   localparam logic        WORD_MODE_RESET    = 1'b0;
   localparam logic [15:0] BUFFER_LIMIT_RESET = 16'hFFFF;

   // result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   // primary header fields
   localparam logic [31:0] HDR_TYPE_MASK  = 32'hC000_0000;
   localparam logic [31:0] HDR_NODE_MASK  = 32'h3FE0_0000;
   localparam logic [31:0] HDR_SHORT_MASK = 32'h001F_0000;
   localparam logic [31:0] HDR_LONG_MASK  = 32'h001F_FFFF;
   localparam logic [15:0] TAG_ERR_MASK   = 16'hF000;

   // smallest lengths that hold a full header, tag and time
   localparam logic [31:0] MIN_LEN_SHORT = 32'd8;
   localparam logic [31:0] MIN_LEN_LONG  = 32'd10;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TAG_ERROR = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_SHORT     = 2'd3
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  block_type;
      logic [8:0]  node_address;
      logic [20:0] data_type;
      logic [15:0] command_tag;
      logic [31:0] data_time;
      logic [15:0] data_count;
      logic [15:0] data_value;
      status_type  status;
      logic [3:0]  tag_error;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

// ----- src/block_deframer_top.sv -----
// Block deframer: parses a byte stream of length-prefixed blocks into header and
// data results. Depends on bdf_pkg.
`default_nettype none

// One request (one byte) is taken every clock cycle unless req_stall is high. Its result, if any, shows up
// in the output register on the next cycle. All parsing state is updated in one
// pass per byte: a 32-bit position counter compared against the 32-bit block
// length, plus the header, tag and time registers. The single output register
// lets a new byte enter while the previous result is being taken; req_stall
// rises only while a result sits in that register and rsp_stall is high.
// Register writes through the csr_ port take effect on the next byte.
module block_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_kind,
   output      logic [1:0]  rsp_block_type,
   output      logic [8:0]  rsp_node_address,
   output      logic [20:0] rsp_data_type,
   output      logic [15:0] rsp_command_tag,
   output      logic [31:0] rsp_data_time,
   output      logic [15:0] rsp_data_count,
   output      logic [15:0] rsp_data_value,
   output      logic [1:0]  rsp_status,
   output      logic [3:0]  rsp_tag_error,
   output      logic        rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   // configuration
   logic        word_mode_ff;
   logic [15:0] buffer_limit_ff;

   // parsing state
   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] hdr_ff, hdr_in;
   logic        long_ff, long_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  high_ff, high_in;
   logic        disc_ff, disc_in;
   logic        body_ff, body_in;

   // output register
   logic                 rsp_valid_ff;
   bdf_pkg::result_type  rsp_ff, rsp_in;

   logic req_accept;
   logic emit;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      logic [31:0] len_shift;
      logic [31:0] k_ext;
      logic [31:0] count;
      logic [15:0] cnt16;
      logic        len_last;
      logic [31:0] hdr_upd, time_upd;
      logic [15:0] tag_upd;
      logic        long_upd, disc_upd, body_upd;
      logic [31:0] pos_upd, len_upd;
      logic [7:0]  high_upd;
      logic        new_pkt;
      logic        r_kind, r_last;
      logic [15:0] r_count, r_value;
      logic [3:0]  r_terr;
      logic [3:0]  terr;
      bdf_pkg::status_type r_status;

      len_shift = {len_ff[23:0], req_data_byte};
      k_ext     = long_ff ? 32'd4 : 32'd2;
      count     = len_ff - k_ext - 32'd6;
      cnt16     = (|count[31:16]) ? 16'hFFFF : count[15:0];
      len_last  = (pos_ff == len_ff - 32'd1);

      hdr_upd  = hdr_ff;
      time_upd = time_ff;
      tag_upd  = tag_ff;
      long_upd = long_ff;
      disc_upd = disc_ff;
      body_upd = body_ff;
      pos_upd  = pos_ff;
      len_upd  = len_ff;
      high_upd = high_ff;
      new_pkt  = 1'b0;
      emit     = 1'b0;
      r_kind   = bdf_pkg::KIND_HEADER;
      r_last   = 1'b0;
      r_count  = 16'd0;
      r_value  = 16'd0;
      r_terr   = 4'd0;
      r_status = bdf_pkg::STATUS_OK;
      terr     = tag_ff[15:12];

      if (req_accept) begin
         if (!body_ff) begin
            // length field, big-endian
            len_upd = len_shift;
            if (pos_ff[1:0] != 2'd3) begin
               pos_upd = pos_ff + 32'd1;
            end else begin
               body_upd = 1'b1;
               pos_upd  = 32'd0;
               if (len_shift < bdf_pkg::MIN_LEN_SHORT) begin
                  emit     = 1'b1;
                  r_status = bdf_pkg::STATUS_SHORT;
                  r_last   = 1'b1;
                  if (len_shift == 32'd0) new_pkt = 1'b1;
                  else disc_upd = 1'b1;
               end
            end
         end else begin
            if (!disc_ff) begin
               if (pos_ff < 32'd2) begin
                  if (pos_ff[0] == 1'b0) begin
                     hdr_upd = hdr_ff | {req_data_byte, 24'd0};
                  end else begin
                     hdr_upd  = hdr_ff | {8'd0, req_data_byte, 16'd0};
                     long_upd = ((hdr_upd & bdf_pkg::HDR_SHORT_MASK)
                                 == bdf_pkg::HDR_SHORT_MASK);
                     if (long_upd && (len_ff < bdf_pkg::MIN_LEN_LONG)) begin
                        emit     = 1'b1;
                        r_status = bdf_pkg::STATUS_SHORT;
                        r_last   = 1'b1;
                        disc_upd = 1'b1;
                     end
                  end
               end else if (pos_ff < k_ext) begin
                  if (pos_ff[0] == 1'b0) hdr_upd = hdr_ff | {16'd0, req_data_byte, 8'd0};
                  else hdr_upd = hdr_ff | {24'd0, req_data_byte};
               end else if (pos_ff < k_ext + 32'd2) begin
                  tag_upd = {tag_ff[7:0], req_data_byte};
               end else if (pos_ff < k_ext + 32'd6) begin
                  time_upd = {time_ff[23:0], req_data_byte};
                  if (pos_ff == k_ext + 32'd5) begin
                     emit    = 1'b1;
                     r_count = cnt16;
                     r_last  = 1'b1;
                     if (terr != 4'd0) begin
                        r_status = bdf_pkg::STATUS_TAG_ERROR;
                        r_terr   = terr;
                        disc_upd = 1'b1;
                     end else if ({16'd0, buffer_limit_ff} < count) begin
                        r_status = bdf_pkg::STATUS_OVERFLOW;
                        disc_upd = 1'b1;
                     end else begin
                        r_last = (count == 32'd0);
                     end
                  end
               end else begin
                  // payload; k is even, so word parity follows pos_ff[0]
                  r_kind  = bdf_pkg::KIND_DATA;
                  r_count = cnt16;
                  r_last  = len_last;
                  if (!word_mode_ff) begin
                     emit    = 1'b1;
                     r_value = {8'd0, req_data_byte};
                  end else if (pos_ff[0] == 1'b0) begin
                     high_upd = req_data_byte;
                     emit     = len_last;
                     r_value  = {req_data_byte, 8'd0};
                  end else begin
                     emit    = 1'b1;
                     r_value = {high_ff, req_data_byte};
                  end
               end
            end
            if (len_last) new_pkt = 1'b1;
            else pos_upd = pos_ff + 32'd1;
         end
      end

      rsp_in.kind         = r_kind;
      rsp_in.block_type   = 2'((hdr_upd & bdf_pkg::HDR_TYPE_MASK) >> 30);
      rsp_in.node_address = 9'((hdr_upd & bdf_pkg::HDR_NODE_MASK) >> 21);
      rsp_in.data_type    = long_upd ? 21'(hdr_upd & bdf_pkg::HDR_LONG_MASK)
                                     : 21'((hdr_upd & bdf_pkg::HDR_SHORT_MASK) >> 16);
      rsp_in.command_tag  = tag_upd;
      rsp_in.data_time    = time_upd;
      rsp_in.data_count   = r_count;
      rsp_in.data_value   = r_value;
      rsp_in.status       = r_status;
      rsp_in.tag_error    = r_terr & bdf_pkg::TAG_ERR_MASK[15:12];
      rsp_in.last         = r_last;

      if (new_pkt) begin
         pos_in  = 32'd0;
         len_in  = 32'd0;
         hdr_in  = 32'd0;
         long_in = 1'b0;
         tag_in  = 16'd0;
         time_in = 32'd0;
         high_in = 8'd0;
         disc_in = 1'b0;
         body_in = 1'b0;
      end else begin
         pos_in  = pos_upd;
         len_in  = len_upd;
         hdr_in  = hdr_upd;
         long_in = long_upd;
         tag_in  = tag_upd;
         time_in = time_upd;
         high_in = high_upd;
         disc_in = disc_upd;
         body_in = body_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_mode_ff    <= bdf_pkg::WORD_MODE_RESET;
         buffer_limit_ff <= bdf_pkg::BUFFER_LIMIT_RESET;
         pos_ff          <= 32'd0;
         len_ff          <= 32'd0;
         hdr_ff          <= 32'd0;
         long_ff         <= 1'b0;
         tag_ff          <= 16'd0;
         time_ff         <= 32'd0;
         high_ff         <= 8'd0;
         disc_ff         <= 1'b0;
         body_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bdf_pkg::CSR_WORD_MODE:    word_mode_ff    <= csr_data[0];
               bdf_pkg::CSR_BUFFER_LIMIT: buffer_limit_ff <= csr_data;
               default: ;
            endcase
         end
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         hdr_ff  <= hdr_in;
         long_ff <= long_in;
         tag_ff  <= tag_in;
         time_ff <= time_in;
         high_ff <= high_in;
         disc_ff <= disc_in;
         body_ff <= body_in;
         if (req_accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_block_type   = rsp_ff.block_type;
   assign rsp_node_address = rsp_ff.node_address;
   assign rsp_data_type    = rsp_ff.data_type;
   assign rsp_command_tag  = rsp_ff.command_tag;
   assign rsp_data_time    = rsp_ff.data_time;
   assign rsp_data_count   = rsp_ff.data_count;
   assign rsp_data_value   = rsp_ff.data_value;
   assign rsp_status       = rsp_ff.status;
   assign rsp_tag_error    = rsp_ff.tag_error;
   assign rsp_last         = rsp_ff.last;

`ifndef SYNTHESIS
   // a held result must never be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("held result changed");

   // the length field takes exactly four bytes
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      !body_ff |-> (pos_ff[31:2] == 30'd0))
      else $error("length position out of range");

   // dropping bytes only happens inside a block body
   a_disc_body: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> body_ff)
      else $error("discarding outside block body");

   // any header error closes the block
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != bdf_pkg::STATUS_OK) |->
         rsp_ff.last && (rsp_ff.kind == bdf_pkg::KIND_HEADER))
      else $error("error result not final header");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for block_deframer_top: drives length-prefixed blocks byte by byte,
// predicts every header and data result and checks them as they come out.
// Depends on bdf_pkg and block_deframer_top.
`timescale 1ns / 1ps

// Tracks the parse state of the byte stream and holds the results still owed.
class deframe_checker;
   logic        word_mode;
   logic [15:0] buffer_limit;
   logic [31:0] position;
   logic [31:0] length;
   logic [31:0] header;
   logic        long_form;
   logic        in_body;
   logic        dropping;
   logic [15:0] tag;
   logic [31:0] stamp;
   logic [7:0]  high_byte;
   bdf_pkg::result_type expected_results[$];
   int          error_count;

   function new();
      word_mode    = bdf_pkg::WORD_MODE_RESET;
      buffer_limit = bdf_pkg::BUFFER_LIMIT_RESET;
      error_count  = 0;
      start_packet();
   endfunction

   function void start_packet();
      position  = 0;
      length    = 0;
      header    = 0;
      long_form = 1'b0;
      in_body   = 1'b0;
      dropping  = 1'b0;
      tag       = 0;
      stamp     = 0;
      high_byte = 0;
   endfunction

   function void apply_csr(logic index, logic [15:0] data);
      if (index == bdf_pkg::CSR_WORD_MODE) word_mode = data[0];
      else buffer_limit = data;
   endfunction

   function void flag(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
   endfunction

   function void queue_result(logic kind, logic [15:0] count, logic [15:0] value,
                              bdf_pkg::status_type status, logic [3:0] tag_err,
                              logic last_flag);
      bdf_pkg::result_type r;
      r.kind         = kind;
      r.block_type   = header[31:30];
      r.node_address = header[29:21];
      r.data_type    = long_form ? header[20:0] : {16'd0, header[20:16]};
      r.command_tag  = tag;
      r.data_time    = stamp;
      r.data_count   = count;
      r.data_value   = value;
      r.status       = status;
      r.tag_error    = tag_err;
      r.last         = last_flag;
      expected_results.push_back(r);
   endfunction

   // Advance the parser by one accepted request.
   function void note_byte(logic [7:0] b);
      logic [31:0] here;
      logic [31:0] k;
      logic [31:0] count;
      logic [31:0] d;
      logic [15:0] cnt16;
      logic        fin;
      if (!in_body) begin
         length = {length[23:0], b};
         if (position < 3) begin
            position++;
            return;
         end
         in_body  = 1'b1;
         position = 0;
         if (length < bdf_pkg::MIN_LEN_SHORT) begin
            queue_result(bdf_pkg::KIND_HEADER, 16'd0, 16'd0, bdf_pkg::STATUS_SHORT,
                         4'd0, 1'b1);
            if (length == 0) start_packet();
            else dropping = 1'b1;
         end
         return;
      end
      here  = position;
      k     = long_form ? 32'd4 : 32'd2;
      count = length - k - 32'd6;
      cnt16 = (count > 32'd65535) ? 16'hFFFF : count[15:0];
      if (!dropping) begin
         if (here == 0) begin
            header[31:24] = b;
         end else if (here == 1) begin
            header[23:16] = b;
            long_form = (header[20:16] == 5'h1F);
            // long header cannot fit: data type low bits never arrive
            if (long_form && length < bdf_pkg::MIN_LEN_LONG) begin
               queue_result(bdf_pkg::KIND_HEADER, 16'd0, 16'd0, bdf_pkg::STATUS_SHORT,
                            4'd0, 1'b1);
               dropping = 1'b1;
            end
         end else if (here < k) begin
            if (here == 2) header[15:8] = b;
            else header[7:0] = b;
         end else if (here < k + 2) begin
            tag = {tag[7:0], b};
         end else if (here < k + 6) begin
            stamp = {stamp[23:0], b};
            if (here == k + 5) begin
               if (tag[15:12] != 4'd0) begin
                  queue_result(bdf_pkg::KIND_HEADER, cnt16, 16'd0,
                               bdf_pkg::STATUS_TAG_ERROR, tag[15:12], 1'b1);
                  dropping = 1'b1;
               end else if ({16'd0, buffer_limit} < count) begin
                  queue_result(bdf_pkg::KIND_HEADER, cnt16, 16'd0,
                               bdf_pkg::STATUS_OVERFLOW, 4'd0, 1'b1);
                  dropping = 1'b1;
               end else begin
                  queue_result(bdf_pkg::KIND_HEADER, cnt16, 16'd0, bdf_pkg::STATUS_OK,
                               4'd0, count == 0);
               end
            end
         end else begin
            d   = here - (k + 6);
            fin = (d == count - 1);
            if (!word_mode) begin
               queue_result(bdf_pkg::KIND_DATA, cnt16, {8'd0, b}, bdf_pkg::STATUS_OK,
                            4'd0, fin);
            end else if (!d[0]) begin
               high_byte = b;
               if (fin) queue_result(bdf_pkg::KIND_DATA, cnt16, {high_byte, 8'd0},
                                     bdf_pkg::STATUS_OK, 4'd0, 1'b1);
            end else begin
               queue_result(bdf_pkg::KIND_DATA, cnt16, {high_byte, b}, bdf_pkg::STATUS_OK,
                            4'd0, fin);
            end
         end
      end
      if (here == length - 1) start_packet();
      else position = here + 1;
   endfunction

   function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v)
         flag($sformatf("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v));
   endfunction

   function void check_result(bdf_pkg::result_type got);
      bdf_pkg::result_type want;
      if (expected_results.size() == 0) begin
         flag($sformatf("result with nothing outstanding: %p", got));
         return;
      end
      want = expected_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("block_type", want.block_type, got.block_type);
      compare("node_address", want.node_address, got.node_address);
      compare("data_type", want.data_type, got.data_type);
      compare("command_tag", want.command_tag, got.command_tag);
      compare("data_time", want.data_time, got.data_time);
      compare("data_count", want.data_count, got.data_count);
      compare("data_value", want.data_value, got.data_value);
      compare("status", want.status, got.status);
      compare("tag_error", want.tag_error, got.tag_error);
      compare("last", want.last, got.last);
   endfunction

   function void check_drained();
      if (expected_results.size() != 0)
         flag($sformatf("%0d results never arrived", expected_results.size()));
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [1:0]  rsp_block_type;
   logic [8:0]  rsp_node_address;
   logic [20:0] rsp_data_type;
   logic [15:0] rsp_command_tag;
   logic [31:0] rsp_data_time;
   logic [15:0] rsp_data_count;
   logic [15:0] rsp_data_value;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_tag_error;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = 16'd0;

   deframe_checker sb;
   logic no_idle = 1'b0;
   int   stall_hold = 0;
   int   cycle_count = 0;
   int   sent_items = 0;

   block_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_block_type   (rsp_block_type),
      .rsp_node_address (rsp_node_address),
      .rsp_data_type    (rsp_data_type),
      .rsp_command_tag  (rsp_command_tag),
      .rsp_data_time    (rsp_data_time),
      .rsp_data_count   (rsp_data_count),
      .rsp_data_value   (rsp_data_value),
      .rsp_status       (rsp_status),
      .rsp_tag_error    (rsp_tag_error),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short idle runs, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      else if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("block_deframer_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < 30);
         stall_hold <= idle_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_byte(req_data_byte);
   end

   always @(posedge clock) begin : rsp_monitor
      bdf_pkg::result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind         = rsp_kind;
         got.block_type   = rsp_block_type;
         got.node_address = rsp_node_address;
         got.data_type    = rsp_data_type;
         got.command_tag  = rsp_command_tag;
         got.data_time    = rsp_data_time;
         got.data_count   = rsp_data_count;
         got.data_value   = rsp_data_value;
         got.status       = bdf_pkg::status_type'(rsp_status);
         got.tag_error    = rsp_tag_error;
         got.last         = rsp_last;
         sb.check_result(got);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = (!no_idle && $urandom_range(0, 99) < 35) ? idle_length() + 1 : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_length(input logic [31:0] len);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // block whose length field is below a full header
   task automatic send_short_frame(input int len);
      send_length(len);
      send_noise(len);
   endtask

   // long header announced in a block too short to hold it
   task automatic send_cut_long(input int len);
      logic [7:0] b;
      b = 8'($urandom);
      b[4:0] = 5'h1F;
      send_length(len);
      send_byte(8'($urandom));
      send_byte(b);
      send_noise(len - 2);
   endtask

   task automatic send_block(input logic [31:0] hdr, input logic [15:0] tag,
                             input logic [31:0] stamp, input int n);
      int k;
      k = (hdr[20:16] == 5'h1F) ? 4 : 2;
      send_length(k + 6 + n);
      send_byte(hdr[31:24]);
      send_byte(hdr[23:16]);
      if (k == 4) begin
         send_byte(hdr[15:8]);
         send_byte(hdr[7:0]);
      end
      send_byte(tag[15:8]);
      send_byte(tag[7:0]);
      send_length(stamp);
      send_noise(n);
   endtask

   // sender holds off until every outstanding result is in, then lets the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.apply_csr(index, data);
      @(posedge clock);
   endtask

   task automatic random_frame();
      int          pick;
      int          n;
      logic [31:0] hdr;
      logic [15:0] tag;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_short_frame($urandom_range(0, 7));
      end else if (pick < 13) begin
         send_cut_long($urandom_range(8, 9));
      end else begin
         hdr = $urandom;
         if ($urandom_range(0, 2) == 0) hdr[20:16] = 5'h1F;
         else if (hdr[20:16] == 5'h1F) hdr[16] = 1'b0;
         tag = 16'($urandom);
         if ($urandom_range(0, 9) != 0) tag[15:12] = 4'd0;
         else if (tag[15:12] == 4'd0) tag[15:12] = 4'($urandom_range(1, 15));
         pick = $urandom_range(0, 99);
         if (pick < 10) n = 0;
         else if (pick < 70) n = $urandom_range(1, 12);
         else if (pick < 95) n = $urandom_range(13, 48);
         else n = $urandom_range(49, 200);
         send_block(hdr, tag, $urandom, n);
      end
   endtask

   task automatic run_phase(input logic wm, input logic [15:0] limit, input int quota);
      logic [14:0] junk;
      int          start;
      junk = 15'($urandom);
      settle();
      write_csr(bdf_pkg::CSR_WORD_MODE, {junk, wm});
      write_csr(bdf_pkg::CSR_BUFFER_LIMIT, limit);
      start = sent_items;
      while (sent_items - start < quota) random_frame();
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: length extremes, both header forms, errors, word packing
      send_short_frame(0);
      send_short_frame(7);
      send_block(32'hFFFE_0000, 16'h0FFF, 32'hFFFF_FFFF, 0);
      send_cut_long(9);
      send_block(32'h001F_FFFF, 16'h0000, 32'h0000_0000, 0);
      send_block(32'h5540_0000, 16'hF000, 32'h1234_5678, 2);
      send_block(32'h8001_0000, 16'h0123, $urandom, 3);
      settle();
      write_csr(bdf_pkg::CSR_WORD_MODE, 16'd1);
      send_block(32'h4002_0000, 16'h0456, $urandom, 3);
      send_block(32'hC03F_ABCD, 16'h0789, $urandom, 4);
      settle();
      write_csr(bdf_pkg::CSR_BUFFER_LIMIT, 16'd0);
      send_block(32'h2003_0000, 16'h0001, $urandom, 1);
      send_block(32'h2003_0000, 16'h1300, $urandom, 5);
      send_block(32'h2003_0000, 16'h0001, $urandom, 0);

      run_phase(1'b1, 16'hFFFF, 75);
      run_phase(1'b0, 16'h0000, 75);
      run_phase(1'b1, 16'h0000, 45);
      run_phase(1'b0, 16'($urandom_range(4, 40)), 75);
      run_phase(1'b1, 16'($urandom), 75);

      // a stretch with no idling
      settle();
      no_idle <= 1'b1;
      run_phase(1'b0, 16'hFFFF, 75);
      settle();
      no_idle <= 1'b0;

      run_phase(1'b1, 16'($urandom_range(4, 40)), 75);
      run_phase(1'b0, 16'hFFFF, 75);

      // last, a block whose count saturates; only its header part is sent
      send_length(32'd65556);
      send_byte(8'h6A);
      send_byte(8'h04);
      send_byte(8'h0A);
      send_byte(8'hBC);
      send_length($urandom);

      settle();
      repeat (10) @(posedge clock);
      sb.check_drained();
      if (sb.error_count == 0) $display("block_deframer_top regression: pass");
      else $display("block_deframer_top regression: fail");
      $finish;
   end

endmodule
